// ----- rtl/core/segment_intersection_2d_unit_macros.svh -----
// Assertion macros shared by the segment intersection RTL.
`ifndef SEGMENT_INTERSECTION_2D_UNIT_MACROS_SVH
`define SEGMENT_INTERSECTION_2D_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SGI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lbl failed");

// Next-cycle implication, also checked across reset.
`define SGI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("lbl failed");

`endif

// ----- rtl/core/sgi_pkg.sv -----
// Shared types and constants for the segment intersection unit.
package sgi_pkg;

    // Operand slice width for the wide scale multiply.
    localparam int SGI_CHUNK_BITS = 24;

    // Control that travels with every pipeline stage.
    typedef struct packed {
        logic valid;
        logic reject;
    } sgi_ctl_t;

endpackage

// ----- rtl/core/sgi_cross.sv -----
// Front pipeline: deltas, cross products, crossing tests and normalization.
module sgi_cross #(
    parameter int N = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [N-1:0]            pa_x,
    input  logic [N-1:0]            pa_y,
    input  logic [N-1:0]            pb_x,
    input  logic [N-1:0]            pb_y,
    input  logic [N-1:0]            pc_x,
    input  logic [N-1:0]            pc_y,
    input  logic [N-1:0]            pd_x,
    input  logic [N-1:0]            pd_y,
    output sgi_pkg::sgi_ctl_t       ctl_o,
    output logic [N-1:0]            ax_o,
    output logic [N-1:0]            ay_o,
    output logic [N:0]              bxm_o,
    output logic                    bxn_o,
    output logic [N:0]              bym_o,
    output logic                    byn_o,
    output logic [2*N+3:0]          tn_o,
    output logic [2*N+3:0]          den_o
);
    import sgi_pkg::*;

    localparam int W1 = N + 1;
    localparam int WK = 2 * N + 3;
    localparam int WD = 2 * N + 4;

    // Stage 1: deltas relative to A, degenerate checks
    sgi_ctl_t               ctl1_reg, ctl1_next;
    logic [N-1:0]           ax1_reg, ay1_reg;
    logic signed [W1-1:0]   bx1_reg, by1_reg, cx1_reg, cy1_reg, dx1_reg, dy1_reg;
    logic signed [W1-1:0]   bx1_next, by1_next, cx1_next, cy1_next, dx1_next, dy1_next;

    always_comb begin
        logic degen;
        degen = (pa_x == pb_x && pa_y == pb_y) || (pc_x == pd_x && pc_y == pd_y)
             || (pa_x == pc_x && pa_y == pc_y) || (pb_x == pc_x && pb_y == pc_y)
             || (pa_x == pd_x && pa_y == pd_y) || (pb_x == pd_x && pb_y == pd_y);
        ctl1_next.valid  = in_valid;
        ctl1_next.reject = degen;
        bx1_next = $signed({pb_x[N-1], pb_x}) - $signed({pa_x[N-1], pa_x});
        by1_next = $signed({pb_y[N-1], pb_y}) - $signed({pa_y[N-1], pa_y});
        cx1_next = $signed({pc_x[N-1], pc_x}) - $signed({pa_x[N-1], pa_x});
        cy1_next = $signed({pc_y[N-1], pc_y}) - $signed({pa_y[N-1], pa_y});
        dx1_next = $signed({pd_x[N-1], pd_x}) - $signed({pa_x[N-1], pa_x});
        dy1_next = $signed({pd_y[N-1], pd_y}) - $signed({pa_y[N-1], pa_y});
    end

    // Stage 2: six cross-product terms
    sgi_ctl_t                 ctl2_reg;
    logic [N-1:0]             ax2_reg, ay2_reg;
    logic signed [W1-1:0]     bx2_reg, by2_reg;
    logic signed [2*W1-1:0]   p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;

    // Stage 3: kc, kd, tn, den and the side test
    sgi_ctl_t                 ctl3_reg, ctl3_next;
    logic [N-1:0]             ax3_reg, ay3_reg;
    logic [W1-1:0]            bxm3_reg, bym3_reg, bxm3_next, bym3_next;
    logic                     bxn3_reg, byn3_reg;
    logic signed [WK-1:0]     tn3_reg, tn3_next;
    logic signed [WD-1:0]     den3_reg, den3_next;

    always_comb begin
        logic signed [WK-1:0] kc, kd;
        kc = WK'(p0_reg) - WK'(p1_reg);
        kd = WK'(p2_reg) - WK'(p3_reg);
        tn3_next  = WK'(p4_reg) - WK'(p5_reg);
        den3_next = WD'(kd) - WD'(kc);
        ctl3_next.valid  = ctl2_reg.valid;
        ctl3_next.reject = ctl2_reg.reject || (kc[WK-1] == kd[WK-1]);
        bxm3_next = bx2_reg[W1-1] ? W1'(-bx2_reg) : W1'(bx2_reg);
        bym3_next = by2_reg[W1-1] ? W1'(-by2_reg) : W1'(by2_reg);
    end

    // Stage 4: make den positive, negating tn with it
    sgi_ctl_t                 ctl4_reg;
    logic [N-1:0]             ax4_reg, ay4_reg;
    logic [W1-1:0]            bxm4_reg, bym4_reg;
    logic                     bxn4_reg, byn4_reg;
    logic signed [WD-1:0]     tn4_reg, den4_reg, tn4_next, den4_next;

    always_comb begin
        if (den3_reg[WD-1]) begin
            den4_next = -den3_reg;
            tn4_next  = -WD'(tn3_reg);
        end else begin
            den4_next = den3_reg;
            tn4_next  = WD'(tn3_reg);
        end
    end

    // Stage 5: crossing must lie on A-B, 0 <= tn <= den
    sgi_ctl_t                 ctl5_next;
    always_comb begin
        ctl5_next.valid  = ctl4_reg.valid;
        ctl5_next.reject = ctl4_reg.reject || tn4_reg[WD-1] || (tn4_reg > den4_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg.valid <= 1'b0;
            ctl2_reg.valid <= 1'b0;
            ctl3_reg.valid <= 1'b0;
            ctl4_reg.valid <= 1'b0;
            ctl_o.valid    <= 1'b0;
        end else if (en) begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl3_next;
            ctl4_reg <= ctl3_reg;
            ctl_o    <= ctl5_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax1_reg <= pa_x;
            ay1_reg <= pa_y;
            bx1_reg <= bx1_next;
            by1_reg <= by1_next;
            cx1_reg <= cx1_next;
            cy1_reg <= cy1_next;
            dx1_reg <= dx1_next;
            dy1_reg <= dy1_next;

            ax2_reg <= ax1_reg;
            ay2_reg <= ay1_reg;
            bx2_reg <= bx1_reg;
            by2_reg <= by1_reg;
            p0_reg  <= bx1_reg * cy1_reg;
            p1_reg  <= by1_reg * cx1_reg;
            p2_reg  <= bx1_reg * dy1_reg;
            p3_reg  <= by1_reg * dx1_reg;
            p4_reg  <= cx1_reg * dy1_reg;
            p5_reg  <= cy1_reg * dx1_reg;

            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            bxm3_reg <= bxm3_next;
            bym3_reg <= bym3_next;
            bxn3_reg <= bx2_reg[W1-1];
            byn3_reg <= by2_reg[W1-1];
            tn3_reg  <= tn3_next;
            den3_reg <= den3_next;

            ax4_reg  <= ax3_reg;
            ay4_reg  <= ay3_reg;
            bxm4_reg <= bxm3_reg;
            bym4_reg <= bym3_reg;
            bxn4_reg <= bxn3_reg;
            byn4_reg <= byn3_reg;
            tn4_reg  <= tn4_next;
            den4_reg <= den4_next;

            ax_o  <= ax4_reg;
            ay_o  <= ay4_reg;
            bxm_o <= bxm4_reg;
            bym_o <= bym4_reg;
            bxn_o <= bxn4_reg;
            byn_o <= byn4_reg;
            tn_o  <= tn4_reg;
            den_o <= den4_reg;
        end
    end

endmodule

// ----- rtl/core/sgi_scale.sv -----
// One coordinate lane: base + round(delta * tn / den) via a pipelined divider.
module sgi_scale #(
    parameter int N = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  sgi_pkg::sgi_ctl_t       ctl_i,
    input  logic [N:0]              mag_i,
    input  logic                    neg_i,
    input  logic [N-1:0]            base_i,
    input  logic [2*N+3:0]          tn_i,
    input  logic [2*N+3:0]          den_i,
    output sgi_pkg::sgi_ctl_t       ctl_o,
    output logic [N-1:0]            res_o
);
    import sgi_pkg::*;

    localparam int W1 = N + 1;
    localparam int WD = 2 * N + 4;
    localparam int WP = W1 + WD;
    localparam int QB = N + 1;
    localparam int CW = SGI_CHUNK_BITS;
    localparam int NC = (WD + CW - 1) / CW;

    // M1: partial products over tn slices
    sgi_ctl_t            ctlm1_reg;
    logic [W1+CW-1:0]    pp_reg [0:NC-1];
    logic [WD-1:0]       denm1_reg;
    logic [N-1:0]        basem1_reg;
    logic                negm1_reg;
    logic [NC*CW-1:0]    tn_pad;

    assign tn_pad = (NC*CW)'(tn_i);

    // Divider pipeline arrays, index 0 loaded from the product sum
    sgi_ctl_t            ctl_reg  [0:QB];
    logic [WD-1:0]       r_reg    [0:QB];
    logic [QB-1:0]       lo_reg   [0:QB];
    logic [QB-1:0]       q_reg    [0:QB];
    logic [WD-1:0]       den_reg  [0:QB];
    logic [N-1:0]        base_reg [0:QB];
    logic                neg_reg  [0:QB];

    logic [WP-1:0]       prod_sum;

    always_comb begin
        prod_sum = '0;
        for (int i = 0; i < NC; i++) begin
            prod_sum = prod_sum + (WP'(pp_reg[i]) << (i * CW));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctlm1_reg.valid <= 1'b0;
            ctl_reg[0].valid <= 1'b0;
        end else if (en) begin
            ctlm1_reg  <= ctl_i;
            ctl_reg[0] <= ctlm1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NC; i++) begin
                pp_reg[i] <= (W1+CW)'(mag_i) * (W1+CW)'(tn_pad[i*CW +: CW]);
            end
            denm1_reg  <= den_i;
            basem1_reg <= base_i;
            negm1_reg  <= neg_i;

            // quotient is below 2^QB, so the high part starts below den
            r_reg[0]    <= prod_sum[WP-1:QB];
            lo_reg[0]   <= prod_sum[QB-1:0];
            q_reg[0]    <= '0;
            den_reg[0]  <= denm1_reg;
            base_reg[0] <= basem1_reg;
            neg_reg[0]  <= negm1_reg;
        end
    end

    // One restoring-division bit per stage
    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [WD-1:0] r2, rn;
        logic          ge;

        always_comb begin
            r2 = {r_reg[k][WD-2:0], lo_reg[k][QB-1]};
            ge = (r2 >= den_reg[k]);
            rn = ge ? (r2 - den_reg[k]) : r2;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[k+1].valid <= 1'b0;
            end else if (en) begin
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k+1]    <= rn;
                lo_reg[k+1]   <= {lo_reg[k][QB-2:0], 1'b0};
                q_reg[k+1]    <= {q_reg[k][QB-2:0], ge};
                den_reg[k+1]  <= den_reg[k];
                base_reg[k+1] <= base_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
            end
        end
    end

    // Round half away from zero, then apply sign and add base
    sgi_ctl_t       ctlr_reg;
    logic [QB-1:0]  qr_reg, qr_next;
    logic [N-1:0]   baser_reg;
    logic           negr_reg;
    logic [N-1:0]   res_next;

    always_comb begin
        logic half;
        half    = ({r_reg[QB], 1'b0} >= {1'b0, den_reg[QB]});
        qr_next = q_reg[QB] + QB'(half);
    end

    always_comb begin
        logic [QB-1:0] sv;
        sv       = negr_reg ? -qr_reg : qr_reg;
        res_next = ctlr_reg.reject ? '0 : (baser_reg + sv[N-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctlr_reg.valid <= 1'b0;
            ctl_o.valid    <= 1'b0;
        end else if (en) begin
            ctlr_reg <= ctl_reg[QB];
            ctl_o    <= ctlr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qr_reg    <= qr_next;
            baser_reg <= base_reg[QB];
            negr_reg  <= neg_reg[QB];
            res_o     <= res_next;
        end
    end

endmodule

// ----- rtl/core/segment_intersection_2d_unit.sv -----
// Throughput: one beat per cycle; the whole pipeline advances while m_tready is high
// or the output stage is empty, so a held result stalls every stage together.
// Depth is set by the divider, one quotient bit per stage (COORD_BITS + 1 stages).
// Reset: synchronous active-low aresetn clears all stage valid bits; data is not reset.
module segment_intersection_2d_unit #(
    parameter int COORD_BITS = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  logic [((8*COORD_BITS+7)/8)*8-1:0]       s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // found, cross_x, cross_y, zero pad
    output logic [((2*COORD_BITS+8)/8)*8-1:0]       m_tdata
);
    import sgi_pkg::*;

    localparam int N  = COORD_BITS;
    localparam int WD = 2 * N + 4;
    localparam int MW = ((2 * N + 8) / 8) * 8;

    logic           en;
    sgi_ctl_t       front_ctl, x_ctl, y_ctl;
    logic [N-1:0]   ax, ay, x_res, y_res;
    logic [N:0]     bxm, bym;
    logic           bxn, byn;
    logic [WD-1:0]  tn, den;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = x_ctl.valid;
    assign m_tdata  = MW'({y_res, x_res, !x_ctl.reject});

    sgi_cross #(.N(N)) u_cross (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .pa_x     (s_tdata[0*N +: N]),
        .pa_y     (s_tdata[1*N +: N]),
        .pb_x     (s_tdata[2*N +: N]),
        .pb_y     (s_tdata[3*N +: N]),
        .pc_x     (s_tdata[4*N +: N]),
        .pc_y     (s_tdata[5*N +: N]),
        .pd_x     (s_tdata[6*N +: N]),
        .pd_y     (s_tdata[7*N +: N]),
        .ctl_o    (front_ctl),
        .ax_o     (ax),
        .ay_o     (ay),
        .bxm_o    (bxm),
        .bxn_o    (bxn),
        .bym_o    (bym),
        .byn_o    (byn),
        .tn_o     (tn),
        .den_o    (den)
    );

    sgi_scale #(.N(N)) u_scale_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_i   (front_ctl),
        .mag_i   (bxm),
        .neg_i   (bxn),
        .base_i  (ax),
        .tn_i    (tn),
        .den_i   (den),
        .ctl_o   (x_ctl),
        .res_o   (x_res)
    );

    sgi_scale #(.N(N)) u_scale_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_i   (front_ctl),
        .mag_i   (bym),
        .neg_i   (byn),
        .base_i  (ay),
        .tn_i    (tn),
        .den_i   (den),
        .ctl_o   (y_ctl),
        .res_o   (y_res)
    );

`include "segment_intersection_2d_unit_macros.svh"

    `SGI_ASSERT_IMP(a_lane_sync, x_ctl.valid || y_ctl.valid, x_ctl == y_ctl)
    `SGI_ASSERT_IMP(a_miss_zero, m_tvalid && x_ctl.reject, x_res == '0 && y_res == '0)
    `SGI_ASSERT_NXT(a_reset_empty, !aresetn, !m_tvalid && !front_ctl.valid)

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the 2D segment intersection unit.
`timescale 1ns / 100ps

module testbench;

    localparam int CB = 32;
    localparam int IN_W = ((8*CB+7)/8)*8;
    localparam int OUT_W = ((2*CB+8)/8)*8;
    localparam int N_RANDOM = 1750;
    localparam int DRAIN_CYCLES = CB + 30;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [CB-1:0] coord_t;
    typedef logic signed [127:0] big_t;

    typedef struct {
        coord_t ax, ay, bx, by, cx, cy, dx, dy;
    } seg_pair_t;

    typedef struct {
        logic   found;
        coord_t px;
        coord_t py;
    } crossing_t;

    class crossing_board;
        crossing_t pending[$];
        int        errors;
        int        checked;
        int        hits;

        function new();
            errors = 0;
            checked = 0;
            hits = 0;
        endfunction

        task report(string what, logic [127:0] got, logic [127:0] want);
            $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
            errors++;
        endtask

        // round(a * tn / den) with ties away from zero, den > 0
        function big_t scale_round(big_t a, big_t tn, big_t den);
            big_t p, mag, q, r;
            p = a * tn;
            mag = (p < 0) ? -p : p;
            q = mag / den;
            r = mag % den;
            if ((r << 1) >= den) q = q + 1;
            return (p < 0) ? -q : q;
        endfunction

        function big_t cross2d(big_t ux, big_t uy, big_t vx, big_t vy);
            return ux * vy - uy * vx;
        endfunction

        function crossing_t find_crossing(seg_pair_t s);
            crossing_t r;
            big_t ax, ay, bx, by, cx, cy, dx, dy, kc, kd, den, tn;
            r.found = 1'b0;
            r.px = '0;
            r.py = '0;
            if ((s.ax == s.bx && s.ay == s.by) || (s.cx == s.dx && s.cy == s.dy)) return r;
            if ((s.ax == s.cx && s.ay == s.cy) || (s.bx == s.cx && s.by == s.cy) ||
                (s.ax == s.dx && s.ay == s.dy) || (s.bx == s.dx && s.by == s.dy)) return r;
            ax = s.ax;
            ay = s.ay;
            bx = big_t'(s.bx) - ax;
            by = big_t'(s.by) - ay;
            cx = big_t'(s.cx) - ax;
            cy = big_t'(s.cy) - ay;
            dx = big_t'(s.dx) - ax;
            dy = big_t'(s.dy) - ay;
            kc = cross2d(bx, by, cx, cy);
            kd = cross2d(bx, by, dx, dy);
            // zero counts as non-negative
            if ((kc < 0) == (kd < 0)) return r;
            den = kd - kc;
            tn = cross2d(cx, cy, dx, dy);
            if (den < 0) begin
                den = -den;
                tn = -tn;
            end
            if (tn < 0 || tn > den) return r;
            r.found = 1'b1;
            r.px = coord_t'(ax + scale_round(bx, tn, den));
            r.py = coord_t'(ay + scale_round(by, tn, den));
            return r;
        endfunction

        function void note(seg_pair_t s);
            pending.push_back(find_crossing(s));
        endfunction

        task check(crossing_t got);
            crossing_t want;
            if (pending.size() == 0) begin
                report("unexpected beat", {got.py, got.px, got.found}, '0);
            end else begin
                want = pending.pop_front();
                checked++;
                if (want.found) hits++;
                if (got.found !== want.found) report("found", got.found, want.found);
                if (got.px !== want.px) report("cross_x", got.px, want.px);
                if (got.py !== want.py) report("cross_y", got.py, want.py);
            end
        endtask
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    crossing_board board;
    int            cycles = 0;

    segment_intersection_2d_unit #(.COORD_BITS(CB)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: done, errors");
            $finish;
        end
    end

    task send_pair(seg_pair_t s);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {s.dy, s.dx, s.cy, s.cx, s.by, s.bx, s.ay, s.ax};
        do @(posedge aclk); while (!s_tready);
        board.note(s);
        @(negedge aclk);
    endtask

    function seg_pair_t mk(int ax, int ay, int bx, int by, int cx, int cy, int dx, int dy);
        seg_pair_t s;
        s.ax = ax; s.ay = ay; s.bx = bx; s.by = by;
        s.cx = cx; s.cy = cy; s.dx = dx; s.dy = dy;
        return s;
    endfunction

    function coord_t rnd_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
            default: return coord_t'($signed($urandom_range(0, 40)) - 20);
        endcase
    endfunction

    task random_pair();
        seg_pair_t s;
        int        mode;
        int        twist;
        mode = $urandom_range(0, 9);
        mode = (mode < 3) ? 0 : (mode < 8) ? 1 : 2;
        s.ax = rnd_coord(mode); s.ay = rnd_coord(mode);
        s.bx = rnd_coord(mode); s.by = rnd_coord(mode);
        s.cx = rnd_coord(mode); s.cy = rnd_coord(mode);
        s.dx = rnd_coord(mode); s.dy = rnd_coord(mode);
        twist = $urandom_range(0, 19);
        // occasionally force degenerate geometry
        case (twist)
            0: begin s.bx = s.ax; s.by = s.ay; end
            1: begin s.dx = s.cx; s.dy = s.cy; end
            2: begin s.cx = s.bx; s.cy = s.by; end
            3: begin s.dx = s.ax; s.dy = s.ay; end
            4: begin s.cx = s.ax; s.cy = s.ay; end
            default: ;
        endcase
        send_pair(s);
    endtask

    initial begin : receiver
        int gap;
        crossing_t got;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.found = m_tdata[0];
            got.px = m_tdata[CB:1];
            got.py = m_tdata[2*CB:CB+1];
            board.check(got);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        board = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // plain X crossing, crossing at A, crossing at B
        send_pair(mk(0, 0, 10, 10, 0, 10, 10, 0));
        send_pair(mk(0, 0, 10, 0, 0, -5, 0, 5));
        send_pair(mk(0, 0, 10, 0, 10, -5, 10, 5));
        // zero length segments
        send_pair(mk(3, 3, 3, 3, 0, 10, 10, 0));
        send_pair(mk(0, 0, 10, 10, 4, 4, 4, 4));
        // shared endpoints
        send_pair(mk(0, 0, 10, 10, 0, 0, 10, 0));
        send_pair(mk(0, 0, 10, 10, 10, 10, 0, 5));
        send_pair(mk(0, 0, 10, 10, 5, 0, 0, 0));
        send_pair(mk(0, 0, 10, 10, 0, 9, 10, 10));
        // same side, touching line from one side, collinear
        send_pair(mk(0, 0, 10, 0, 0, 1, 10, 5));
        send_pair(mk(0, 0, 10, 0, 0, -1, 10, -5));
        send_pair(mk(0, 0, 10, 0, 5, 0, 5, 5));
        send_pair(mk(0, 0, 10, 0, 5, -5, 5, 0));
        send_pair(mk(0, 0, 10, 0, 2, 0, 7, 0));
        // crossing beyond B and behind A
        send_pair(mk(0, 0, 10, 0, 15, -5, 15, 5));
        send_pair(mk(0, 0, 10, 0, -3, -5, -3, 5));
        // crossing exactly at A, then a rounding tie
        send_pair(mk(0, 0, 1, 0, 1, -1, -2, 2));
        send_pair(mk(0, 0, 1, 1, 1, 0, 0, 1));
        // full range extremes
        send_pair(mk(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
        send_pair(mk(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                     32'h8000_0000, 32'h8000_0000, 32'h7fff_fffe, 32'h7fff_ffff));
        send_pair(mk(-1, -1, 0, 32'h8000_0000, 32'h7fff_ffff, -2, 32'h8000_0001, -3));
        send_pair(mk(32'h0001_8000, 0, 32'hfffe_8000, 0, 0, 32'h7fff_ffff, 0, 32'h8000_0000));

        repeat (N_RANDOM) random_pair();
        s_tvalid = 1'b0;

        while (board.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("checked %0d result beats, %0d with an intersection found",
                 board.checked, board.hits);
        $display("stimulus mixed full-range, mid-range and tiny-grid pairs with degenerate cases");
        if (board.errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/sgi_pkg.sv
rtl/core/sgi_cross.sv
rtl/core/sgi_scale.sv
rtl/core/segment_intersection_2d_unit.sv
verif/testbench.sv
